// ===== src/tidnn_pkg.sv =====
// shared types and constants of the nearest-neighbor touch tracker
package tidnn_pkg;

  localparam int IDW  = 16;  // touch id width
  localparam int XW   = 12;  // coordinate width
  localparam int CFGW = 13;  // distance register width
  localparam int SQW  = 26;  // square of a distance register
  localparam int DW   = 25;  // squared distance of two coordinate pairs
  localparam int ENW  = IDW + 2 * XW;

  localparam logic REG_TRAVEL = 1'b0;
  localparam logic REG_FILTER = 1'b1;

  localparam logic FUNC_TOUCH = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIMITS,
    ST_LIM_LOAD,
    ST_SCAN,
    ST_TAKEN,
    ST_PICK,
    ST_CHOOSE,
    ST_FIND,
    ST_FDIST,
    ST_FCMP,
    ST_DONE
  } state_t;

endpackage

// ===== src/touch_id_nearest_neighbor_tracker_unit.sv =====
// touch id tracker: history scan, nearest-neighbor vote and position filter
//
// Touch centers enter on the in_ channel (valid/ready), one transaction per
// touch, in_last_in_frame marking the frame's last touch. A transaction with
// in_func set is an empty frame: it clears the history and gives no result.
// Each touch gives one transaction on the out_ channel with its id, reported
// position, moved flag and a copy of the last-of-frame mark.
// The history memory holds FRAMES+1 frame slots of MAX_TOUCHES entries; the
// spare slot collects the current frame, so a finished frame needs no copy.
// Per touch the block streams every stored entry through one squaring unit,
// one entry per cycle within a frame, keeping the NEAREST best in a sorted
// register list, then scans the current frame for taken ids, votes over the
// list one entry a cycle and scans the newest frame for the filter match.
// An empty-frame transaction is handled in the idle state. One touch is in
// work at a time. The result sits in an output register; a new touch is
// accepted while it waits, and the next result waits only if out_ready is
// still low. Reset (rst_n low, synchronous) empties the history, restarts
// ids at zero and loads max_travel_distance 25 and movement_filter 0.
module touch_id_nearest_neighbor_tracker_unit
  import tidnn_pkg::*;
#(
  parameter int FRAMES      = 10,
  parameter int MAX_TOUCHES = 16,
  parameter int NEAREST     = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  // touch channel
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_func,
  input  logic [XW-1:0]   in_pos_x,
  input  logic [XW-1:0]   in_pos_y,
  input  logic            in_last_in_frame,
  // result channel
  output logic            out_valid,
  input  logic            out_ready,
  output logic [IDW-1:0]  out_touch_id,
  output logic [XW-1:0]   out_x,
  output logic [XW-1:0]   out_y,
  output logic            out_moved,
  output logic            out_last_out,
  // register port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int SLOTS = FRAMES + 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int TW    = (MAX_TOUCHES > 1) ? $clog2(MAX_TOUCHES) : 1;
  localparam int CW    = $clog2(MAX_TOUCHES + 1);
  localparam int FW    = $clog2(FRAMES + 1);
  localparam int PW    = FW + TW;
  localparam int KW    = DW + IDW + PW;
  localparam int LW    = (NEAREST > 1) ? $clog2(NEAREST) : 1;
  localparam int VCW   = $clog2(NEAREST + 1);
  localparam int AW    = SW + TW;
  localparam int DEPTH = 1 << AW;

  function automatic logic [CFGW-1:0] abs_diff(input logic [XW-1:0] a,
                                               input logic [XW-1:0] b);
    logic [XW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {1'b0, d};
  endfunction

  state_t state_r, state_nxt;

  // registers and memory
  logic [CFGW-1:0] travel_r, filter_r;
  logic [ENW-1:0]  mem [DEPTH];
  logic [ENW-1:0]  rd_data_r;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;
  logic [AW-1:0]   wr_addr;
  logic [ENW-1:0]  wr_data;

  logic [CW-1:0]   counts_r [SLOTS];
  logic [SW-1:0]   head_r, head_nxt;
  logic [FW-1:0]   stored_r, stored_nxt;
  logic [CW-1:0]   cur_count_r, cur_count_nxt;
  logic [IDW-1:0]  fresh_r, fresh_nxt;
  logic            cnt_we;

  logic [XW-1:0]   in_x_r, in_x_nxt, in_y_r, in_y_nxt;
  logic            in_last_r, in_last_nxt;

  // scan iterator over logical frames
  logic            it_act_r, it_act_nxt;
  logic [FW-1:0]   it_f_r, it_f_nxt, it_last_r, it_last_nxt;
  logic [CW-1:0]   it_t_r, it_t_nxt;
  logic [SW:0]     it_sum;
  logic [SW-1:0]   it_slot;
  logic [CW-1:0]   it_cnt;
  logic            issue;

  // read pipeline
  logic            p1_v_r, p1_v_nxt, p2_v_r, p2_v_nxt;
  logic [PW-1:0]   p1_pos_r, p1_pos_nxt, p2_pos_r, p2_pos_nxt;
  logic [IDW-1:0]  p2_id_r, p2_id_nxt;
  logic [CFGW-1:0] mul_a, mul_b;
  logic [SQW-1:0]  sqa_r, sqb_r;
  logic [SQW:0]    sq_sum;
  logic [IDW-1:0]  rd_id;
  logic [XW-1:0]   rd_x, rd_y;

  logic [SQW-1:0]  lim_travel_r, lim_travel_nxt, lim_filter_r, lim_filter_nxt;

  // nearest list
  logic [KW-1:0]   ln_key_r [NEAREST];
  logic [KW-1:0]   ln_key_nxt [NEAREST];
  logic [NEAREST-1:0] ln_v_r, ln_v_nxt, lt, in_reach;
  logic [NEAREST-1:0] taken_r, taken_nxt;
  logic [KW-1:0]   new_key;

  // vote
  logic [LW-1:0]   pk_j_r, pk_j_nxt;
  logic            have_r, have_nxt;
  logic [IDW-1:0]  best_id_r, best_id_nxt;
  logic [VCW-1:0]  best_cnt_r, best_cnt_nxt, vc;
  logic [IDW-1:0]  jid;

  // result
  logic [IDW-1:0]  id_r, id_nxt;
  logic            found_r, found_nxt;
  logic [XW-1:0]   fx_r, fx_nxt, fy_r, fy_nxt;
  logic [XW-1:0]   ox_r, ox_nxt, oy_r, oy_nxt;
  logic            moved_r, moved_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [IDW-1:0]  o_id_r, o_id_nxt;
  logic [XW-1:0]   o_x_r, o_x_nxt, o_y_r, o_y_nxt;
  logic            o_moved_r, o_moved_nxt, o_last_r, o_last_nxt;

  logic [SW-1:0]   cur_slot;
  logic [CW-1:0]   cnt_after;
  logic            out_free;

  // register port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_TRAVEL: prdata[CFGW-1:0] = travel_r;
      REG_FILTER: prdata[CFGW-1:0] = filter_r;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      travel_r <= CFGW'(25);
      filter_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_TRAVEL: travel_r <= pwdata[CFGW-1:0];
        REG_FILTER: filter_r <= pwdata[CFGW-1:0];
        default:    travel_r <= travel_r;
      endcase
    end
  end

  // history memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_id = rd_data_r[ENW-1 -: IDW];
  assign rd_x  = rd_data_r[2*XW-1 -: XW];
  assign rd_y  = rd_data_r[XW-1:0];

  // logical frame to slot, newest frame at head
  assign it_sum  = {1'b0, head_r} + (SW+1)'(it_f_r);
  assign it_slot = (it_sum >= (SW+1)'(SLOTS)) ? SW'(it_sum - (SW+1)'(SLOTS)) : it_sum[SW-1:0];
  assign it_cnt  = (it_f_r == FW'(FRAMES)) ? cur_count_r : counts_r[it_slot];
  assign issue   = it_act_r && (it_t_r < it_cnt);
  assign rd_addr = {it_slot, it_t_r[TW-1:0]};

  assign cur_slot  = (head_r == '0) ? SW'(SLOTS - 1) : (head_r - 1'b1);
  assign cnt_after = (cur_count_r < CW'(MAX_TOUCHES)) ? (cur_count_r + 1'b1) : cur_count_r;
  assign out_free  = !out_valid_r || out_ready;

  // shared squaring unit
  always_comb begin
    case (state_r)
      ST_LIMITS: begin
        mul_a = travel_r;
        mul_b = filter_r;
      end
      ST_FDIST: begin
        mul_a = abs_diff(in_x_r, fx_r);
        mul_b = abs_diff(in_y_r, fy_r);
      end
      default: begin
        mul_a = abs_diff(in_x_r, rd_x);
        mul_b = abs_diff(in_y_r, rd_y);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sqa_r <= mul_a * mul_a;
    sqb_r <= mul_b * mul_b;
  end

  assign sq_sum  = {1'b0, sqa_r} + {1'b0, sqb_r};
  assign new_key = {sq_sum[DW-1:0], p2_id_r, p2_pos_r};

  // sorted insertion and vote lanes
  always_comb begin
    for (int i = 0; i < NEAREST; i++) begin
      lt[i]       = !ln_v_r[i] || (new_key < ln_key_r[i]);
      in_reach[i] = ln_v_r[i] && ({1'b0, ln_key_r[i][KW-1 -: DW]} <= lim_travel_r);
    end
  end

  always_comb begin
    jid = ln_key_r[pk_j_r][KW-DW-1 -: IDW];
    vc  = '0;
    for (int k = 0; k < NEAREST; k++) begin
      if (in_reach[k] && (ln_key_r[k][KW-DW-1 -: IDW] == jid)) vc = vc + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_func == FUNC_TOUCH)
          state_nxt = (stored_r == '0) ? ST_CHOOSE : ST_LIMITS;
      end
      ST_LIMITS:   state_nxt = ST_LIM_LOAD;
      ST_LIM_LOAD: state_nxt = ST_SCAN;
      ST_SCAN:     if (!it_act_r && !p1_v_r && !p2_v_r) state_nxt = ST_TAKEN;
      ST_TAKEN:    if (!it_act_r && !p1_v_r) state_nxt = ST_PICK;
      ST_PICK:     if (pk_j_r == LW'(NEAREST - 1)) state_nxt = ST_CHOOSE;
      ST_CHOOSE:   state_nxt = (stored_r == '0) ? ST_FCMP : ST_FIND;
      ST_FIND:     if (!it_act_r && !p1_v_r) state_nxt = ST_FDIST;
      ST_FDIST:    state_nxt = ST_FCMP;
      ST_FCMP:     state_nxt = ST_DONE;
      ST_DONE:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    head_nxt       = head_r;
    stored_nxt     = stored_r;
    cur_count_nxt  = cur_count_r;
    fresh_nxt      = fresh_r;
    cnt_we         = 1'b0;
    mem_we         = 1'b0;
    wr_addr        = {cur_slot, cur_count_r[TW-1:0]};
    wr_data        = {id_r, ox_r, oy_r};
    in_x_nxt       = in_x_r;
    in_y_nxt       = in_y_r;
    in_last_nxt    = in_last_r;
    it_act_nxt     = it_act_r;
    it_f_nxt       = it_f_r;
    it_t_nxt       = it_t_r;
    it_last_nxt    = it_last_r;
    p1_v_nxt       = issue;
    p1_pos_nxt     = {it_f_r, it_t_r[TW-1:0]};
    p2_v_nxt       = p1_v_r && (state_r == ST_SCAN);
    p2_pos_nxt     = p1_pos_r;
    p2_id_nxt      = rd_id;
    lim_travel_nxt = lim_travel_r;
    lim_filter_nxt = lim_filter_r;
    ln_v_nxt       = ln_v_r;
    ln_key_nxt     = ln_key_r;
    taken_nxt      = taken_r;
    pk_j_nxt       = pk_j_r;
    have_nxt       = have_r;
    best_id_nxt    = best_id_r;
    best_cnt_nxt   = best_cnt_r;
    id_nxt         = id_r;
    found_nxt      = found_r;
    fx_nxt         = fx_r;
    fy_nxt         = fy_r;
    ox_nxt         = ox_r;
    oy_nxt         = oy_r;
    moved_nxt      = moved_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    o_id_nxt       = o_id_r;
    o_x_nxt        = o_x_r;
    o_y_nxt        = o_y_r;
    o_moved_nxt    = o_moved_r;
    o_last_nxt     = o_last_r;

    // iterator step
    if (it_act_r) begin
      if (issue) begin
        it_t_nxt = it_t_r + 1'b1;
      end else if (it_f_r == it_last_r) begin
        it_act_nxt = 1'b0;
      end else begin
        it_f_nxt = it_f_r + 1'b1;
        it_t_nxt = '0;
      end
    end

    case (state_r)
      ST_IDLE: begin
        in_x_nxt    = in_pos_x;
        in_y_nxt    = in_pos_y;
        in_last_nxt = in_last_in_frame;
        have_nxt    = 1'b0;
        found_nxt   = 1'b0;
        if (in_valid && in_func == FUNC_CLEAR) begin
          stored_nxt    = '0;
          cur_count_nxt = '0;
        end
      end
      ST_LIM_LOAD: begin
        lim_travel_nxt = sqa_r;
        lim_filter_nxt = sqb_r;
        ln_v_nxt       = '0;
        it_act_nxt     = 1'b1;
        it_f_nxt       = '0;
        it_t_nxt       = '0;
        it_last_nxt    = stored_r - 1'b1;
      end
      ST_SCAN: begin
        if (p2_v_r) begin
          for (int i = 0; i < NEAREST; i++) begin
            if (lt[i]) begin
              if (i == 0) ln_key_nxt[i] = new_key;
              else if (!lt[i-1]) ln_key_nxt[i] = new_key;
              else ln_key_nxt[i] = ln_key_r[i-1];
            end
            if (i == 0) ln_v_nxt[i] = 1'b1;
            else ln_v_nxt[i] = ln_v_r[i] | ln_v_r[i-1];
          end
        end
        if (state_nxt == ST_TAKEN) begin
          taken_nxt   = '0;
          it_act_nxt  = 1'b1;
          it_f_nxt    = FW'(FRAMES);
          it_t_nxt    = '0;
          it_last_nxt = FW'(FRAMES);
        end
      end
      ST_TAKEN: begin
        if (p1_v_r) begin
          for (int i = 0; i < NEAREST; i++) begin
            if (ln_key_r[i][KW-DW-1 -: IDW] == rd_id) taken_nxt[i] = 1'b1;
          end
        end
        pk_j_nxt = '0;
      end
      ST_PICK: begin
        if (in_reach[pk_j_r] && !taken_r[pk_j_r] &&
            (!have_r || vc > best_cnt_r || (vc == best_cnt_r && jid < best_id_r))) begin
          have_nxt     = 1'b1;
          best_id_nxt  = jid;
          best_cnt_nxt = vc;
        end
        pk_j_nxt = pk_j_r + 1'b1;
      end
      ST_CHOOSE: begin
        if (have_r) begin
          id_nxt = best_id_r;
        end else begin
          id_nxt    = fresh_r;
          fresh_nxt = fresh_r + 1'b1;
        end
        it_act_nxt  = (stored_r != '0);
        it_f_nxt    = '0;
        it_t_nxt    = '0;
        it_last_nxt = '0;
      end
      ST_FIND: begin
        if (p1_v_r && !found_r && rd_id == id_r) begin
          found_nxt = 1'b1;
          fx_nxt    = rd_x;
          fy_nxt    = rd_y;
        end
      end
      ST_FCMP: begin
        if (found_r && (sq_sum < {1'b0, lim_filter_r})) begin
          ox_nxt    = fx_r;
          oy_nxt    = fy_r;
          moved_nxt = 1'b0;
        end else begin
          ox_nxt    = in_x_r;
          oy_nxt    = in_y_r;
          moved_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_id_nxt      = id_r;
          o_x_nxt       = ox_r;
          o_y_nxt       = oy_r;
          o_moved_nxt   = moved_r;
          o_last_nxt    = in_last_r;
          mem_we        = (cur_count_r < CW'(MAX_TOUCHES));
          cur_count_nxt = cnt_after;
          if (in_last_r) begin
            cnt_we        = 1'b1;
            head_nxt      = cur_slot;
            stored_nxt    = (stored_r == FW'(FRAMES)) ? stored_r : (stored_r + 1'b1);
            cur_count_nxt = '0;
          end
        end
      end
      default: begin
        pk_j_nxt = pk_j_r;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      stored_r    <= '0;
      cur_count_r <= '0;
      fresh_r     <= '0;
      it_act_r    <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ln_v_r      <= '0;
      for (int s = 0; s < SLOTS; s++) counts_r[s] <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      stored_r    <= stored_nxt;
      cur_count_r <= cur_count_nxt;
      fresh_r     <= fresh_nxt;
      it_act_r    <= it_act_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p2_v_nxt;
      out_valid_r <= out_valid_nxt;
      ln_v_r      <= ln_v_nxt;
      if (cnt_we) counts_r[cur_slot] <= cnt_after;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    in_x_r       <= in_x_nxt;
    in_y_r       <= in_y_nxt;
    in_last_r    <= in_last_nxt;
    it_f_r       <= it_f_nxt;
    it_t_r       <= it_t_nxt;
    it_last_r    <= it_last_nxt;
    p1_pos_r     <= p1_pos_nxt;
    p2_pos_r     <= p2_pos_nxt;
    p2_id_r      <= p2_id_nxt;
    lim_travel_r <= lim_travel_nxt;
    lim_filter_r <= lim_filter_nxt;
    ln_key_r     <= ln_key_nxt;
    taken_r      <= taken_nxt;
    pk_j_r       <= pk_j_nxt;
    have_r       <= have_nxt;
    best_id_r    <= best_id_nxt;
    best_cnt_r   <= best_cnt_nxt;
    id_r         <= id_nxt;
    found_r      <= found_nxt;
    fx_r         <= fx_nxt;
    fy_r         <= fy_nxt;
    ox_r         <= ox_nxt;
    oy_r         <= oy_nxt;
    moved_r      <= moved_nxt;
    o_id_r       <= o_id_nxt;
    o_x_r        <= o_x_nxt;
    o_y_r        <= o_y_nxt;
    o_moved_r    <= o_moved_nxt;
    o_last_r     <= o_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_touch_id = o_id_r;
  assign out_x        = o_x_r;
  assign out_y        = o_y_r;
  assign out_moved    = o_moved_r;
  assign out_last_out = o_last_r;

endmodule

// ===== dv/tb_touch_id_nearest_neighbor_tracker_unit.sv =====
// testbench for the nearest-neighbor touch tracker: frame stimulus, id predictor, result check
`timescale 1ns / 100ps

module tb_touch_id_nearest_neighbor_tracker_unit
  import tidnn_pkg::*;
;

  localparam int NFR = 10;
  localparam int NTC = 16;
  localparam int NNB = 5;
  localparam int SETTLE = 260;

  typedef struct {
    logic          func;
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic          last;
  } touch_t;

  typedef struct {
    logic [IDW-1:0] id;
    logic [XW-1:0]  x;
    logic [XW-1:0]  y;
    logic           moved;
    logic           last;
  } track_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic in_func = FUNC_TOUCH, in_last_in_frame = 1'b0;
  logic [XW-1:0] in_pos_x = '0, in_pos_y = '0;
  logic out_valid, out_ready = 1'b0;
  logic [IDW-1:0] out_touch_id;
  logic [XW-1:0] out_x, out_y;
  logic out_moved, out_last_out;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  touch_t touch_q[$];
  track_t track_q[$];
  touch_t cur_touch;
  bit quiet = 0;
  bit hold_off = 0;
  int in_gap = 0, out_gap = 0;
  int mismatches = 0;

  // predictor state
  logic [IDW-1:0] hist_id[NFR][NTC];
  logic [XW-1:0]  hist_x[NFR][NTC], hist_y[NFR][NTC];
  int             hist_cnt[NFR];
  int             frames_kept;
  logic [IDW-1:0] frame_id[NTC];
  logic [XW-1:0]  frame_x[NTC], frame_y[NTC];
  int             frame_cnt;
  logic [IDW-1:0] next_id;
  logic [CFGW-1:0] travel_reg, filter_reg;

  // finger model for well-formed frames
  int fx[18], fy[18];
  int nfing;

  always #10 clk = ~clk;

  touch_id_nearest_neighbor_tracker_unit u_dut (.*);

  function automatic longint sq_dist(int ax, int ay, int bx, int by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    return dx * dx + dy * dy;
  endfunction

  function automatic bit key_lt(longint d1, int i1, int p1, longint d2, int i2, int p2);
    if (d1 != d2) return d1 < d2;
    if (i1 != i2) return i1 < i2;
    return p1 < p2;
  endfunction

  function automatic logic [IDW-1:0] take_fresh();
    logic [IDW-1:0] id;
    id = next_id;
    next_id = next_id + 1'b1;
    return id;
  endfunction

  // vote among the nearest stored touches, lower id wins ties
  function automatic logic [IDW-1:0] vote_id(int x, int y);
    int cid[NNB], cnt[NNB];
    int ncand, best, c, p;
    longint lim, d, bd, pd;
    int bi, bp, pi, pp;
    bit found, have_prev, taken;
    ncand = 0;
    have_prev = 0;
    pd = 0; pi = 0; pp = 0;
    lim = longint'(travel_reg) * longint'(travel_reg);
    for (int n = 0; n < NNB; n++) begin
      found = 0; bd = 0; bi = 0; bp = 0;
      for (int f = 0; f < frames_kept; f++)
        for (int t = 0; t < hist_cnt[f]; t++) begin
          d = sq_dist(x, y, hist_x[f][t], hist_y[f][t]);
          p = f * NTC + t;
          if (have_prev && !key_lt(pd, pi, pp, d, hist_id[f][t], p)) continue;
          if (!found || key_lt(d, hist_id[f][t], p, bd, bi, bp)) begin
            found = 1; bd = d; bi = hist_id[f][t]; bp = p;
          end
        end
      if (!found || bd > lim) break;
      for (c = 0; c < ncand; c++) if (cid[c] == bi) break;
      if (c < ncand) cnt[c]++;
      else begin
        cid[ncand] = bi; cnt[ncand] = 1; ncand++;
      end
      have_prev = 1; pd = bd; pi = bi; pp = bp;
    end
    best = -1;
    for (c = 0; c < ncand; c++) begin
      taken = 0;
      for (int i = 0; i < frame_cnt; i++) if (frame_id[i] == cid[c]) taken = 1;
      if (taken) continue;
      if (best < 0 || cnt[c] > cnt[best] || (cnt[c] == cnt[best] && cid[c] < cid[best]))
        best = c;
    end
    if (best < 0) return take_fresh();
    return IDW'(cid[best]);
  endfunction

  // advance the tracker state by one accepted transaction
  task automatic track_touch(touch_t tc);
    track_t r;
    longint lim;
    if (tc.func == FUNC_CLEAR) begin
      frames_kept = 0;
      foreach (hist_cnt[f]) hist_cnt[f] = 0;
      frame_cnt = 0;
      return;
    end
    r.x = tc.x; r.y = tc.y; r.moved = 1'b1; r.last = tc.last;
    if (frames_kept == 0) r.id = take_fresh();
    else begin
      lim = longint'(filter_reg) * longint'(filter_reg);
      r.id = vote_id(tc.x, tc.y);
      for (int t = 0; t < hist_cnt[0]; t++)
        if (hist_id[0][t] == r.id) begin
          if (sq_dist(tc.x, tc.y, hist_x[0][t], hist_y[0][t]) < lim) begin
            r.x = hist_x[0][t]; r.y = hist_y[0][t]; r.moved = 1'b0;
          end
          break;
        end
    end
    if (frame_cnt < NTC) begin
      frame_id[frame_cnt] = r.id; frame_x[frame_cnt] = r.x; frame_y[frame_cnt] = r.y;
      frame_cnt++;
    end
    if (tc.last) begin
      if (frames_kept >= NFR) frames_kept = NFR - 1;
      for (int f = frames_kept; f > 0; f--) begin
        hist_id[f] = hist_id[f-1]; hist_x[f] = hist_x[f-1]; hist_y[f] = hist_y[f-1];
        hist_cnt[f] = hist_cnt[f-1];
      end
      hist_id[0] = frame_id; hist_x[0] = frame_x; hist_y[0] = frame_y;
      hist_cnt[0] = frame_cnt;
      frames_kept++;
      frame_cnt = 0;
    end
    track_q.push_back(r);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_touch(cur_touch);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (touch_q.size() > 0 && !hold_off) begin
          cur_touch = touch_q.pop_front();
          in_func <= cur_touch.func;
          in_pos_x <= cur_touch.x;
          in_pos_y <= cur_touch.y;
          in_last_in_frame <= cur_touch.last;
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    track_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (track_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result id=%0d", out_touch_id);
        end else begin
          e = track_q.pop_front();
          if (out_touch_id !== e.id || out_x !== e.x || out_y !== e.y ||
              out_moved !== e.moved || out_last_out !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp id=%0d x=%0d y=%0d moved=%0b last=%0b, ",
                        "got id=%0d x=%0d y=%0d moved=%0b last=%0b"},
                       e.id, e.x, e.y, e.moved, e.last,
                       out_touch_id, out_x, out_y, out_moved, out_last_out);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 11);
      end
    end
  end

  task automatic add_touch(int x, int y, bit last);
    touch_t tc;
    tc.func = FUNC_TOUCH; tc.x = XW'(x); tc.y = XW'(y); tc.last = last;
    touch_q.push_back(tc);
  endtask

  task automatic add_clear();
    touch_t tc;
    tc.func = FUNC_CLEAR; tc.x = XW'($urandom); tc.y = XW'($urandom);
    tc.last = 1'($urandom);
    touch_q.push_back(tc);
  endtask

  // wait until all work has drained and the block sits idle
  task automatic drain();
    wait (touch_q.size() == 0 && !in_valid && track_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [CFGW-1:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {$urandom_range(0, 1) ? 19'h7ffff : 19'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_TRAVEL) travel_reg = val;
    else filter_reg = val;
  endtask

  task automatic set_regs(int travel, int filter);
    drain();
    reg_write(REG_TRAVEL, CFGW'(travel));
    reg_write(REG_FILTER, CFGW'(filter));
  endtask

  // fingers drift a little each frame, sometimes appear or vanish; some frames are random touches or clears
  task automatic random_frames(int count);
    int sent, r;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        add_clear();
        sent++;
        continue;
      end
      if (r < 8) begin
        repeat ($urandom_range(1, 4))
          add_touch($urandom_range(0, 4095), $urandom_range(0, 4095), 0);
        add_touch($urandom_range(0, 4095), $urandom_range(0, 4095), 1);
        sent += 2;
        continue;
      end
      if (r < 20 && nfing < 18) begin
        fx[nfing] = $urandom_range(0, 4095); fy[nfing] = $urandom_range(0, 4095); nfing++;
      end else if (r < 28 && nfing > 1) begin
        nfing--;
      end
      for (int i = 0; i < nfing; i++) begin
        fx[i] += $urandom_range(0, 40) - 20;
        fy[i] += $urandom_range(0, 40) - 20;
        if (fx[i] < 0) fx[i] = 0;
        if (fx[i] > 4095) fx[i] = 4095;
        if (fy[i] < 0) fy[i] = 0;
        if (fy[i] > 4095) fy[i] = 4095;
        add_touch(fx[i], fy[i], i == nfing - 1);
      end
      sent += nfing;
    end
  endtask

  initial begin
    frames_kept = 0; frame_cnt = 0; next_id = '0;
    foreach (hist_cnt[f]) hist_cnt[f] = 0;
    travel_reg = 13'd25; filter_reg = '0;
    nfing = 3;
    fx[0] = 500; fy[0] = 500; fx[1] = 2000; fy[1] = 1000; fx[2] = 3500; fy[2] = 3000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: fresh ids on empty history, corners, small moves
    add_touch(0, 0, 0); add_touch(4095, 4095, 0); add_touch(100, 100, 1);
    add_touch(2, 1, 0); add_touch(4095, 4090, 0); add_touch(110, 105, 1);
    // two touches near one old touch: the second finds its id taken
    add_touch(111, 104, 0); add_touch(112, 106, 1);
    // empty frame, then mid-frame clear
    add_clear();
    add_touch(4095, 0, 0); add_touch(0, 4095, 1);
    add_touch(4094, 1, 0); add_clear(); add_touch(4000, 10, 1);
    // frame overflow
    for (int i = 0; i < 18; i++) add_touch(i * 200, i * 200, i == 17);

    // widest travel and filter
    set_regs(8191, 8191);
    add_touch(10, 10, 0); add_touch(4095, 4095, 1);
    add_touch(20, 30, 1);
    set_regs(0, 0);
    add_touch(20, 30, 0); add_touch(21, 30, 1);

    // random frames under varied settings
    set_regs(25, 0);
    random_frames(150);
    set_regs($urandom_range(10, 60), $urandom_range(1, 10));
    random_frames(150);
    // sender holds until every result is back
    drain();
    hold_off = 1;
    random_frames(20);
    repeat (50) @(posedge clk);
    hold_off = 0;
    set_regs($urandom_range(30, 200), $urandom_range(0, 30));
    random_frames(100);
    drain();
    quiet = 1;
    random_frames(80);
    drain();

    if (mismatches == 0 && track_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tidnn_pkg.sv
src/touch_id_nearest_neighbor_tracker_unit.sv
dv/tb_touch_id_nearest_neighbor_tracker_unit.sv
